### rtl/websocket_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// shared concurrent assertion wrappers, sampled on clk with rst_n low masking
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WSD_ASSERT_IMP(lbl, ante, cons, msg)
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants shared by the websocket frame deframer modules
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam logic [3:0] OPCODE_TEXT = 4'd1;
    localparam logic [6:0] MAX_LEN     = 7'd125;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_EXT_LEN = 2'd1;
    localparam logic [1:0] ERR_NOT_TXT = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_MASK    = 3'd2,
        PH_TEXT    = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] error_code;
    } result_t;

    typedef struct packed {
        logic   halted;
        phase_t phase;
    } parse_status_t;

endpackage

`default_nettype wire

### rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// frame header decode, mask capture and payload unmasking, one byte per beat
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    output logic               has_result,
    output result_t            result,
    output parse_status_t      status
);

    phase_t     phase_reg,     phase_next;
    logic [3:0] opcode_reg,    opcode_next;
    logic       masked_reg,    masked_next;
    logic [6:0] bytes_left_reg, bytes_left_next;
    logic [1:0] pos_reg,       pos_next;
    logic       halted_reg,    halted_next;
    logic [7:0] key_reg [4];
    logic       key_wr;

    logic       do_start;
    logic [6:0] start_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            opcode_reg     <= '0;
            masked_reg     <= 1'b0;
            bytes_left_reg <= '0;
            pos_reg        <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            masked_reg     <= masked_next;
            bytes_left_reg <= bytes_left_next;
            pos_reg        <= pos_next;
            halted_reg     <= halted_next;
        end
    end

    // key bytes are always written before a masked payload reads them
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_reg[pos_reg] <= rx_byte;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        masked_next     = masked_reg;
        bytes_left_next = bytes_left_reg;
        pos_next        = pos_reg;
        halted_next     = halted_reg;
        key_wr          = 1'b0;
        has_result      = 1'b0;
        result          = '0;
        do_start        = 1'b0;
        start_len       = bytes_left_reg;

        if (accept && !halted_reg)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    if (rx_byte[6:0] > MAX_LEN)
                    begin
                        halted_next       = 1'b1;
                        phase_next        = PH_HDR0;
                        has_result        = 1'b1;
                        result.error_code = ERR_EXT_LEN;
                    end
                    else
                    begin
                        bytes_left_next = rx_byte[6:0];
                        if (rx_byte[7])
                        begin
                            pos_next   = '0;
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            do_start  = 1'b1;
                            start_len = rx_byte[6:0];
                        end
                    end
                end
                PH_MASK:
                begin
                    key_wr   = 1'b1;
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        do_start = 1'b1;
                    end
                end
                PH_TEXT:
                begin
                    pos_next            = pos_reg + 2'd1;
                    bytes_left_next     = bytes_left_reg - 7'd1;
                    has_result          = 1'b1;
                    result.byte_valid   = 1'b1;
                    result.payload_byte = masked_reg ? (rx_byte ^ key_reg[pos_reg]) : rx_byte;
                    if (bytes_left_reg == 7'd1)
                    begin
                        result.frame_end = 1'b1;
                        phase_next       = PH_HDR0;
                    end
                end
                PH_DISCARD:
                begin
                    pos_next        = pos_reg + 2'd1;
                    bytes_left_next = bytes_left_reg - 7'd1;
                    if (bytes_left_reg == 7'd1)
                    begin
                        halted_next       = 1'b1;
                        phase_next        = PH_HDR0;
                        has_result        = 1'b1;
                        result.error_code = ERR_NOT_TXT;
                    end
                end
                default:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            // header (and key) complete, choose the payload path
            if (do_start)
            begin
                pos_next = '0;
                if (opcode_reg == OPCODE_TEXT)
                begin
                    if (start_len == 7'd0)
                    begin
                        phase_next       = PH_HDR0;
                        has_result       = 1'b1;
                        result.frame_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                    end
                end
                else if (start_len == 7'd0)
                begin
                    halted_next       = 1'b1;
                    phase_next        = PH_HDR0;
                    has_result        = 1'b1;
                    result.error_code = ERR_NOT_TXT;
                end
                else
                begin
                    phase_next = PH_DISCARD;
                end
            end
        end
    end

    assign status.halted = halted_reg;
    assign status.phase  = phase_reg;

endmodule

`default_nettype wire

### rtl/wsd_out_buf.sv
// ----------------------------------------------------------------------------
// wsd_out_buf
// result register with a skid entry so input acceptance does not wait on out_ready
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out_buf
    import wsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_data,
    output logic          push_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

endmodule

`default_nettype wire

### rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side frame parser with payload unmasking
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, back to back, for as long as
// the two-entry result buffer (output register plus skid entry) has room;
// in_ready drops only when both entries hold untaken results. A result
// appears on the output the cycle after the byte that causes it, unless an
// earlier result is still waiting there. Key bytes give no result, nor do
// discarded bytes but the last (the not-text error); header bytes give one
// only for an empty text frame or an error, as does the last key byte of
// an empty masked frame. After an error (length over 125, or a frame that
// is not text) the block keeps taking bytes but gives nothing until reset.
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             frame_end,
    output logic [1:0]       error_code
);

    logic          accept;
    logic          has_result;
    result_t       result;
    result_t       out_data;
    parse_status_t status;

    assign accept = in_valid && in_ready;

    wsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .has_result (has_result),
        .result     (result),
        .status     (status)
    );

    wsd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (has_result),
        .push_data  (result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign payload_byte = out_data.payload_byte;
    assign byte_valid   = out_data.byte_valid;
    assign frame_end    = out_data.frame_end;
    assign error_code   = out_data.error_code;

    `WSD_ASSERT_IMP(a_data_no_err, out_valid && byte_valid, error_code == ERR_NONE, "data beat carries an error code")
    `WSD_ASSERT_IMP(a_err_beat_clean, out_valid && (error_code != ERR_NONE), !frame_end && !byte_valid && (payload_byte == 8'd0), "error beat carries data or frame end")
    `WSD_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "halt cleared without reset")
    `WSD_ASSERT_IMP(a_empty_ready, !out_valid, in_ready, "input stalled with empty result buffer")

endmodule

`default_nettype wire
